// File: rtl/core/gwwm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy word-wrap measure package
// Command codes, character constants and the saturating add shared by the
// text measuring core.
// ----------------------------------------------------------------------------
package gwwm_pkg;

    localparam int ADVANCE_BITS_DEFAULT = 8;

    localparam int GLYPH_COUNT = 95;
    localparam int GLYPH_IDX_BITS = $clog2(GLYPH_COUNT);

    localparam logic [7:0] GLYPH_FIRST = 8'd32;
    localparam logic [7:0] GLYPH_END = 8'd127;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_NEWLINE = 8'd10;

    localparam int DIM_BITS = 16;
    localparam logic [DIM_BITS-1:0] DIM_MAX = '1;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_CHAR = 2'd1;
    localparam logic [1:0] CMD_END = 2'd2;

    localparam logic CFG_WRAP_LIMIT = 1'b0;
    localparam logic CFG_ROW_HEIGHT = 1'b1;

    typedef logic [DIM_BITS-1:0] dim_t;

    function automatic dim_t sat_add(input dim_t a, input dim_t b);
        logic [DIM_BITS:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[DIM_BITS] ? DIM_MAX : sum[DIM_BITS-1:0];
    endfunction

endpackage

// File: rtl/core/greedy_word_wrap_measure_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy word-wrap measure
// Measures the bounding box of greedily wrapped text, one byte per beat, using
// a loadable table of glyph advances.
// ----------------------------------------------------------------------------
//  Channel  Signals                              Beat contents
//  in       in_valid, in_stall                   cmd, code, advance_value
//  out      out_valid, out_stall                 text_width, text_height
//  cfg      cfg_valid, cfg_ready                 cfg_index, cfg_data
//
//  One beat is taken every cycle unless an end command is held in the input register;
//  a beat waits there while the advance table is read, and the running sums update from it.
//  An end command's result is registered on the output when the command leaves the input register.
//  Reset clears the advance table through per-entry valid bits and all sums.
//  An end command waits in the input register while an earlier result is
//  stalled on the output, and the input stalls behind it.
// ----------------------------------------------------------------------------
module greedy_word_wrap_measure_top #(
    parameter int ADVANCE_BITS = gwwm_pkg::ADVANCE_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  code,
    input  logic [7:0]  advance_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] text_width,
    output logic [15:0] text_height,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int IDX_BITS = gwwm_pkg::GLYPH_IDX_BITS;

    logic [ADVANCE_BITS-1:0] adv_mem [gwwm_pkg::GLYPH_COUNT];
    logic [gwwm_pkg::GLYPH_COUNT-1:0] adv_vld_reg;
    logic [ADVANCE_BITS-1:0] rd_data_reg;
    logic rd_vld_reg;

    logic in_accept;
    logic in_print;
    logic [IDX_BITS-1:0] in_idx;
    logic [7:0] in_off;

    logic s1_valid_reg;
    logic [1:0] s1_cmd_reg;
    logic [7:0] s1_code_reg;
    logic s1_print_reg;
    logic s1_fire;

    logic [15:0] wrap_limit_reg;
    logic [7:0] row_height_reg;

    gwwm_pkg::dim_t word_width_reg, word_width_next;
    logic word_open_reg, word_open_next;
    gwwm_pkg::dim_t line_width_reg, line_width_next;
    logic line_open_reg, line_open_next;
    gwwm_pkg::dim_t widest_reg, widest_next;
    gwwm_pkg::dim_t height_reg, height_next;

    logic out_valid_reg;
    gwwm_pkg::dim_t out_width_reg, out_height_reg;

    gwwm_pkg::dim_t adv;
    gwwm_pkg::dim_t word_grown;
    gwwm_pkg::dim_t cw_word;
    logic [16:0] trial_sum;
    logic do_wrap;
    gwwm_pkg::dim_t line1, widest1, height1;
    gwwm_pkg::dim_t widest2, height2;
    logic is_nl, is_space;

    assign in_off = code - gwwm_pkg::GLYPH_FIRST;
    assign in_idx = in_off[IDX_BITS-1:0];
    assign in_print = (code >= gwwm_pkg::GLYPH_FIRST) && (code < gwwm_pkg::GLYPH_END);
    assign s1_fire = s1_valid_reg
        && ((s1_cmd_reg != gwwm_pkg::CMD_END) || !out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && !s1_fire;
    assign in_accept = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk)
    begin
        if (in_accept && (cmd == gwwm_pkg::CMD_LOAD) && in_print)
        begin
            adv_mem[in_idx] <= ADVANCE_BITS'(advance_value);
        end
        if (in_accept && in_print)
        begin
            rd_data_reg <= adv_mem[in_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            adv_vld_reg <= '0;
            rd_vld_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            rd_vld_reg <= in_print ? adv_vld_reg[in_idx] : 1'b0;
            if ((cmd == gwwm_pkg::CMD_LOAD) && in_print)
            begin
                adv_vld_reg[in_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_cmd_reg <= cmd;
            s1_code_reg <= code;
            s1_print_reg <= in_print;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_limit_reg <= '0;
            row_height_reg <= 8'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                gwwm_pkg::CFG_WRAP_LIMIT: wrap_limit_reg <= cfg_data;
                gwwm_pkg::CFG_ROW_HEIGHT: row_height_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        is_nl = (s1_code_reg == gwwm_pkg::CH_NEWLINE);
        is_space = (s1_code_reg == gwwm_pkg::CH_SPACE);
        adv = (s1_print_reg && rd_vld_reg) ? 16'(rd_data_reg) : '0;
        word_grown = gwwm_pkg::sat_add(word_width_reg, adv);
        cw_word = (s1_cmd_reg == gwwm_pkg::CMD_CHAR) ? word_grown : word_width_reg;

        trial_sum = {1'b0, line_width_reg} + {1'b0, cw_word};
        do_wrap = line_open_reg && (wrap_limit_reg != '0)
            && (trial_sum > {1'b0, wrap_limit_reg});

        line1 = line_width_reg;
        widest1 = widest_reg;
        height1 = height_reg;
        if ((s1_cmd_reg == gwwm_pkg::CMD_CHAR && is_space) || word_open_reg)
        begin
            if (do_wrap)
            begin
                widest1 = (line_width_reg > widest_reg) ? line_width_reg : widest_reg;
                height1 = gwwm_pkg::sat_add(height_reg, 16'(row_height_reg));
                line1 = cw_word;
            end
            else
            begin
                line1 = gwwm_pkg::sat_add(line_width_reg, cw_word);
            end
        end
        widest2 = (line1 > widest1) ? line1 : widest1;
        height2 = gwwm_pkg::sat_add(height1, 16'(row_height_reg));

        word_width_next = word_width_reg;
        word_open_next = word_open_reg;
        line_width_next = line_width_reg;
        line_open_next = line_open_reg;
        widest_next = widest_reg;
        height_next = height_reg;
        case (s1_cmd_reg)
            gwwm_pkg::CMD_CHAR:
            begin
                if (is_nl)
                begin
                    word_width_next = '0;
                    word_open_next = 1'b0;
                    line_width_next = '0;
                    line_open_next = 1'b0;
                    widest_next = widest2;
                    height_next = height2;
                end
                else if (is_space)
                begin
                    word_width_next = '0;
                    word_open_next = 1'b0;
                    line_width_next = line1;
                    line_open_next = 1'b1;
                    widest_next = widest1;
                    height_next = height1;
                end
                else
                begin
                    word_width_next = word_grown;
                    word_open_next = 1'b1;
                end
            end
            gwwm_pkg::CMD_END:
            begin
                word_width_next = '0;
                word_open_next = 1'b0;
                line_width_next = '0;
                line_open_next = 1'b0;
                widest_next = '0;
                height_next = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_width_reg <= '0;
            word_open_reg <= 1'b0;
            line_width_reg <= '0;
            line_open_reg <= 1'b0;
            widest_reg <= '0;
            height_reg <= '0;
        end
        else if (s1_fire)
        begin
            word_width_reg <= word_width_next;
            word_open_reg <= word_open_next;
            line_width_reg <= line_width_next;
            line_open_reg <= line_open_next;
            widest_reg <= widest_next;
            height_reg <= height_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && (s1_cmd_reg == gwwm_pkg::CMD_END))
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && (s1_cmd_reg == gwwm_pkg::CMD_END))
        begin
            out_width_reg <= widest2;
            out_height_reg <= height2;
        end
    end

    assign out_valid = out_valid_reg;
    assign text_width = out_width_reg;
    assign text_height = out_height_reg;

    a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (s1_cmd_reg == gwwm_pkg::CMD_END) |=> out_valid_reg)
        else $error("end command did not produce a result");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (s1_cmd_reg == gwwm_pkg::CMD_END)
        |=> !line_open_reg && !word_open_reg && (height_reg == '0))
        else $error("running state not cleared after end command");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && (s1_cmd_reg == gwwm_pkg::CMD_END))
        else $error("input stalled without a blocked end command");

    a_result_from_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(s1_fire) && ($past(s1_cmd_reg) == gwwm_pkg::CMD_END))
        else $error("result appeared without an end command");

    a_close_line_height: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && (s1_cmd_reg == gwwm_pkg::CMD_CHAR) && (s1_code_reg == gwwm_pkg::CH_NEWLINE)
        |=> !line_open_reg && (line_width_reg == '0))
        else $error("newline did not close the line");

endmodule

// File: sim/gwwm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy word-wrap measure checker
// Watches the input, output and register channels of the text measuring core.
// It keeps its own advance table, register copies and running sums, works out
// the bounding box that each end command should give, and compares every
// result beat field by field with the oldest box still waiting.
// ----------------------------------------------------------------------------
module gwwm_checker #(
    parameter int ADVANCE_BITS = gwwm_pkg::ADVANCE_BITS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  code,
    input  logic [7:0]  advance_value,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [15:0] text_width,
    input  logic [15:0] text_height,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data,
    output int          errors,
    output int          pending,
    output int          boxes_checked
);

    localparam gwwm_pkg::dim_t ADV_MASK = gwwm_pkg::dim_t'((32'd1 << ADVANCE_BITS) - 1);
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        gwwm_pkg::dim_t width;
        gwwm_pkg::dim_t height;
    } box_t;

    box_t           expected_boxes[$];
    gwwm_pkg::dim_t advances[gwwm_pkg::GLYPH_COUNT];
    gwwm_pkg::dim_t wrap_limit;
    logic [7:0]     row_height;
    gwwm_pkg::dim_t word_w;
    gwwm_pkg::dim_t line_w;
    gwwm_pkg::dim_t widest;
    gwwm_pkg::dim_t height_sum;
    logic           word_open;
    logic           line_open;

    function automatic gwwm_pkg::dim_t clamp_sum(input gwwm_pkg::dim_t a,
                                                 input gwwm_pkg::dim_t b);
        int unsigned s;
        s = a + b;
        return (s > 32'd65535) ? gwwm_pkg::DIM_MAX : gwwm_pkg::dim_t'(s);
    endfunction

    task automatic clear_text();
        word_w = '0;
        word_open = 1'b0;
        line_w = '0;
        line_open = 1'b0;
        widest = '0;
        height_sum = '0;
    endtask

    task automatic end_word();
        int unsigned joined;
        if (word_open)
        begin
            joined = line_w + word_w;
            if (line_open && wrap_limit != '0 && joined > wrap_limit)
            begin
                if (line_w > widest)
                    widest = line_w;
                height_sum = clamp_sum(height_sum, gwwm_pkg::dim_t'(row_height));
                line_w = word_w;
            end
            else
            begin
                line_w = clamp_sum(line_w, word_w);
            end
            line_open = 1'b1;
            word_w = '0;
            word_open = 1'b0;
        end
    endtask

    task automatic end_line();
        end_word();
        if (line_w > widest)
            widest = line_w;
        height_sum = clamp_sum(height_sum, gwwm_pkg::dim_t'(row_height));
        line_w = '0;
        line_open = 1'b0;
    endtask

    task automatic measure_beat(input logic [1:0] c, input logic [7:0] k, input logic [7:0] a);
        box_t box;
        if (c == gwwm_pkg::CMD_LOAD)
        begin
            if (k >= gwwm_pkg::GLYPH_FIRST && k < gwwm_pkg::GLYPH_END)
                advances[k - gwwm_pkg::GLYPH_FIRST] = gwwm_pkg::dim_t'(a) & ADV_MASK;
        end
        else if (c == gwwm_pkg::CMD_CHAR)
        begin
            if (k == gwwm_pkg::CH_NEWLINE)
            begin
                end_line();
            end
            else
            begin
                word_open = 1'b1;
                if (k >= gwwm_pkg::GLYPH_FIRST && k < gwwm_pkg::GLYPH_END)
                    word_w = clamp_sum(word_w, advances[k - gwwm_pkg::GLYPH_FIRST]);
                if (k == gwwm_pkg::CH_SPACE)
                    end_word();
            end
        end
        else if (c == gwwm_pkg::CMD_END)
        begin
            end_line();
            box.width = widest;
            box.height = height_sum;
            expected_boxes.push_back(box);
            clear_text();
        end
    endtask

    task automatic check_box(input gwwm_pkg::dim_t w, input gwwm_pkg::dim_t h);
        box_t box;
        if (expected_boxes.size() == 0)
        begin
            errors++;
            if (errors <= REPORT_LIMIT)
                $display("Result beat with no box waiting: width %0d height %0d", w, h);
        end
        else
        begin
            box = expected_boxes.pop_front();
            boxes_checked++;
            if (w !== box.width || h !== box.height)
            begin
                errors++;
                if (errors <= REPORT_LIMIT)
                    $display("Box mismatch: expected width %0d height %0d, got width %0d height %0d",
                             box.width, box.height, w, h);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_boxes.delete();
            for (int i = 0; i < gwwm_pkg::GLYPH_COUNT; i++)
                advances[i] = '0;
            wrap_limit = '0;
            row_height = 8'd16;
            clear_text();
            errors = 0;
            pending = 0;
            boxes_checked = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == gwwm_pkg::CFG_WRAP_LIMIT)
                    wrap_limit = cfg_data;
                else
                    row_height = cfg_data[7:0];
            end
            if (out_valid && !out_stall)
                check_box(text_width, text_height);
            if (in_valid && !in_stall)
                measure_beat(cmd, code, advance_value);
            pending = expected_boxes.size();
        end
    end

endmodule

// File: sim/tb_greedy_word_wrap_measure_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Greedy word-wrap measure testbench
// Drives the text measuring core with a short directed text, a text that
// drives every sum into saturation, a burst of end commands against a long
// output hold, and random texts under a range of wrap widths and line heights.
// Both channels idle at random; the checker predicts and compares every box.
// ----------------------------------------------------------------------------
module tb_greedy_word_wrap_measure_top;

    localparam int ADV_BITS = gwwm_pkg::ADVANCE_BITS_DEFAULT;
    localparam int RUN_LIMIT = 500000;
    localparam int RANDOM_BEATS = 350;
    localparam int HOLD_CYCLES = 150;
    localparam int SETTLE_CYCLES = 6;
    localparam int MAX_GAP = 14;

    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam logic [7:0] CH_A = 8'd97;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [7:0] CH_CTRL = 8'd1;
    localparam logic [7:0] CH_TOP = 8'd255;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = gwwm_pkg::CMD_LOAD;
    logic [7:0]  code = 8'd0;
    logic [7:0]  advance_value = 8'd0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] text_width;
    logic [15:0] text_height;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = gwwm_pkg::CFG_WRAP_LIMIT;
    logic [15:0] cfg_data = 16'd0;

    int          errors;
    int          pending;
    int          boxes_checked;
    int          cycles = 0;
    int          text_beats = 0;
    int          settings = 0;
    int          holds_asked = 0;
    int          holds_done = 0;
    logic        steady = 1'b0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    greedy_word_wrap_measure_top #(
        .ADVANCE_BITS (ADV_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .code          (code),
        .advance_value (advance_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .text_width    (text_width),
        .text_height   (text_height),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    gwwm_checker #(
        .ADVANCE_BITS (ADV_BITS)
    ) chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .cmd           (cmd),
        .code          (code),
        .advance_value (advance_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .text_width    (text_width),
        .text_height   (text_height),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending),
        .boxes_checked (boxes_checked)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == RUN_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d boxes outstanding", cycles, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // The receiver may stall before each result beat; a requested hold keeps it
    // stalled long enough for the core to fill up and push back on its input.
    initial
    begin : receiver
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (holds_done < holds_asked)
            begin
                holds_done++;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                n = steady ? 0 : $urandom_range(0, MAX_GAP);
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n) @(negedge clk);
                end
            end
            out_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(out_valid && !out_stall));
        end
    end

    task automatic send_beat(input logic [1:0] c, input logic [7:0] k, input logic [7:0] a);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd <= c;
        code <= k;
        advance_value <= a;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        if (!(c == CMD_NONE || (c == gwwm_pkg::CMD_LOAD
              && (k < gwwm_pkg::GLYPH_FIRST || k >= gwwm_pkg::GLYPH_END))))
            text_beats++;
    endtask

    task automatic send_char(input logic [7:0] k);
        send_beat(gwwm_pkg::CMD_CHAR, k, 8'($urandom_range(0, 255)));
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] val);
        @(negedge clk);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic set_layout(input logic [15:0] wrap, input logic [7:0] lh);
        drain();
        write_reg(gwwm_pkg::CFG_WRAP_LIMIT, wrap);
        write_reg(gwwm_pkg::CFG_ROW_HEIGHT, {8'($urandom_range(0, 255)), lh});
        settings++;
    endtask

    function automatic logic [7:0] pick_glyph();
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(33, 126));
    endfunction

    task automatic send_text(input int words);
        int len;
        int r;
        for (int i = 0; i < words; i++)
        begin
            len = $urandom_range(1, 8);
            for (int j = 0; j < len; j++)
                send_char(pick_glyph());
            r = $urandom_range(0, 99);
            if (r < 70)
                send_char(gwwm_pkg::CH_SPACE);
            else if (r < 85)
                send_char(gwwm_pkg::CH_NEWLINE);
            else if (r < 92)
                send_char(8'($urandom_range(0, 255)));
            else if (r < 96)
                send_beat(CMD_NONE, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            else
                send_beat(gwwm_pkg::CMD_LOAD, 8'($urandom_range(0, 255)),
                          8'($urandom_range(0, 31)));
        end
        send_beat(gwwm_pkg::CMD_END, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    endtask

    task automatic reload_advances(input int count);
        logic [7:0] a;
        for (int i = 0; i < count; i++)
        begin
            a = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 15));
            send_beat(gwwm_pkg::CMD_LOAD, 8'($urandom_range(32, 126)), a);
        end
    endtask

    initial
    begin : stimulus
        int phase;
        logic [15:0] wrap;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty text under the reset registers gives one line of height.
        send_beat(gwwm_pkg::CMD_END, 8'd0, 8'd0);
        set_layout(16'd10, 8'd255);
        send_beat(gwwm_pkg::CMD_LOAD, CH_A, 8'd3);
        send_beat(gwwm_pkg::CMD_LOAD, gwwm_pkg::CH_SPACE, 8'd1);
        send_beat(gwwm_pkg::CMD_LOAD, CH_TILDE, 8'd255);
        send_beat(gwwm_pkg::CMD_LOAD, gwwm_pkg::GLYPH_FIRST - 8'd1, 8'd200);
        send_beat(gwwm_pkg::CMD_LOAD, gwwm_pkg::GLYPH_END, 8'd200);
        send_beat(CMD_NONE, CH_A, 8'd9);
        send_char(CH_A);
        send_char(CH_A);
        send_char(gwwm_pkg::CH_SPACE);
        send_char(CH_A);
        send_char(gwwm_pkg::CH_SPACE);
        send_char(CH_CTRL);
        send_char(gwwm_pkg::CH_SPACE);
        send_char(gwwm_pkg::CH_NEWLINE);
        send_char(CH_TILDE);
        send_char(CH_TOP);
        send_beat(gwwm_pkg::CMD_END, CH_TOP, 8'd255);

        // Word, line and height sums all run into saturation.
        set_layout(16'hFFFF, 8'd255);
        steady = 1'b1;
        repeat (260) send_char(CH_TILDE);
        send_char(gwwm_pkg::CH_SPACE);
        send_char(CH_TILDE);
        send_char(gwwm_pkg::CH_SPACE);
        repeat (258) send_char(gwwm_pkg::CH_NEWLINE);
        send_beat(gwwm_pkg::CMD_END, 8'd0, 8'd0);

        // A long output hold while one-character texts, each with its end command, keep arriving.
        set_layout(16'd40, 8'd7);
        holds_asked++;
        for (int i = 0; i < 16; i++)
        begin
            send_char(CH_A);
            send_beat(gwwm_pkg::CMD_END, 8'd0, 8'd0);
        end
        steady = 1'b0;
        text_beats = 0;

        phase = 0;
        while (text_beats < RANDOM_BEATS)
        begin
            case (phase % 5)
                0: set_layout(16'd0, 8'd0);
                1: set_layout(16'hFFFF, 8'd255);
                2: set_layout(16'd1, 8'($urandom_range(0, 255)));
                3:
                begin
                    wrap = 16'($urandom_range(0, 65535));
                    set_layout(wrap, 8'($urandom_range(0, 255)));
                end
                default: set_layout(16'($urandom_range(8, 120)), 8'($urandom_range(1, 40)));
            endcase
            steady = ($urandom_range(0, 3) == 0);
            reload_advances($urandom_range(4, 20));
            repeat (4) send_text($urandom_range(0, 12));
            phase++;
        end

        drain();
        repeat (20) @(negedge clk);
        $display("Checked %0d boxes from %0d counted beats over %0d register settings,",
                 boxes_checked, text_beats, settings);
        $display("including saturated sums, ignored beats and a long output hold.");
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/gwwm_pkg.sv
rtl/core/greedy_word_wrap_measure_top.sv
sim/gwwm_checker.sv
sim/tb_greedy_word_wrap_measure_top.sv
